// ===== rtl/kts_pkg.sv =====
// Package for the keyframe tween sequencer: sizes, field widths, codes,
// shared structs and the elaboration-time sine/cosine tween tables.
// No dependencies.
package kts_pkg;

  localparam int CHANNELS         = 8;
  localparam int KEYFRAMES        = 16;
  localparam int VALUE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int CH_BITS    = $clog2(CHANNELS);
  localparam int KF_BITS    = $clog2(KEYFRAMES);
  localparam int GOAL_DEPTH = KEYFRAMES * CHANNELS;
  localparam int GOAL_AW    = KF_BITS + CH_BITS;
  localparam int LUT_BITS   = $clog2(SINE_TABLE_DEPTH);

  // Field widths of the channels
  localparam int CMD_W    = 2;
  localparam int TIME_W   = 32;
  localparam int ENTRY_W  = 4;
  localparam int CHAN_W   = 3;
  localparam int DUR_W    = 16;
  localparam int MASK_W   = 8;
  localparam int MODE_W   = 3;
  localparam int COUNT_W  = 5;
  localparam int TW_W     = 17;   // Q1.16 weight, 0..65536
  localparam int T_W      = 16;   // Q0.16 phase, below one

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    OP_TICK = 2'd0,
    OP_LOAD = 2'd1,
    OP_PLAY = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOOP  = 2'd0,
    REG_MODE  = 2'd1,
    REG_COUNT = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    TW_LINEAR = 3'd0,
    TW_SQUARE = 3'd1,
    TW_CUBIC  = 3'd2,
    TW_SINE   = 3'd3,
    TW_COSINE = 3'd4
  } tween_e;

  typedef struct packed {
    logic               loop_en;
    logic [MODE_W-1:0]  tween_mode;
    logic [COUNT_W-1:0] kf_count;
  } cfg_t;

  typedef struct packed {
    op_e                          op;
    logic [TIME_W-1:0]            now_ms;
    logic [ENTRY_W-1:0]           entry;
    logic [CHAN_W-1:0]            chan;
    logic signed [VALUE_BITS-1:0] goal;
    logic [DUR_W-1:0]             dur;
    logic [MASK_W-1:0]            mask;
    logic                         load_ok;
  } op_t;

  localparam longint Q30_ONE     = 64'sd1 << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Shift-and-subtract quotient of two non-negative values
  function automatic longint udiv64(input longint num, input longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'sd1);
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // Quarter-wave Taylor series in Q30: sine when odd is set, else cosine
  function automatic longint series_q30(input longint x, input logic odd);
    longint term;
    longint sum;
    longint n;
    term = odd ? x : Q30_ONE;
    sum  = term;
    n    = odd ? 64'sd1 : 64'sd0;
    for (int k = 1; k <= 6; k++) begin
      term = (((term * x) >>> 30) * x) >>> 30;
      term = udiv64(term, (n + 1) * (n + 2));
      n    = n + 2;
      if (k % 2 == 1) sum = sum - term;
      else            sum = sum + term;
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  // Build the half-shifted sine or cosine weight table, one Q1.16 entry per index
  function automatic logic [SINE_TABLE_DEPTH*TW_W-1:0] build_trig_lut(input logic cosine);
    logic [SINE_TABLE_DEPTH*TW_W-1:0] lut;
    longint q4, quad, u, x, s, c, v, r;
    lut = '0;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      q4   = 4 * longint'(i);
      quad = q4 / SINE_TABLE_DEPTH;
      u    = ((q4 % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
      x    = (u * HALF_PI_Q30) >>> 30;
      s    = series_q30(x, 1'b1);
      c    = series_q30(x, 1'b0);
      if (!cosine) begin
        v = (quad == 0) ? s : (quad == 1) ? c : (quad == 2) ? -s : -c;
      end else begin
        v = (quad == 0) ? c : (quad == 1) ? -s : (quad == 2) ? -c : s;
      end
      r = Q30_ONE + v + (64'sd1 <<< 14);
      if (r < 0) r = 0;
      r = r >>> 15;
      if (r > 65536) r = 65536;
      lut[i*TW_W +: TW_W] = TW_W'(r);
    end
    return lut;
  endfunction

  localparam logic [SINE_TABLE_DEPTH*TW_W-1:0] SIN_LUT = build_trig_lut(1'b0);
  localparam logic [SINE_TABLE_DEPTH*TW_W-1:0] COS_LUT = build_trig_lut(1'b1);

endpackage

// ===== rtl/kts_if.sv =====
// Channel interfaces of the keyframe tween sequencer: item, result, config.
// Depends on kts_pkg.
interface kts_item_if;
  import kts_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             cmd;
  logic [TIME_W-1:0]            now_ms;
  logic [ENTRY_W-1:0]           entry_index;
  logic [CHAN_W-1:0]            channel_index;
  logic signed [VALUE_BITS-1:0] goal_value;
  logic [DUR_W-1:0]             entry_duration;
  logic [MASK_W-1:0]            entry_mask;
  modport source (output valid, cmd, now_ms, entry_index, channel_index, goal_value,
                  entry_duration, entry_mask, input ready);
  modport sink (input valid, cmd, now_ms, entry_index, channel_index, goal_value,
                entry_duration, entry_mask, output ready);
endinterface

interface kts_res_if;
  import kts_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [CHAN_W-1:0]            out_channel;
  logic signed [VALUE_BITS-1:0] out_value;
  logic                         is_playing;
  logic [COUNT_W-1:0]           frame_now;
  logic                         last;
  modport source (output valid, out_channel, out_value, is_playing, frame_now, last,
                  input ready);
  modport sink (input valid, out_channel, out_value, is_playing, frame_now, last,
                output ready);
endinterface

interface kts_cfg_if;
  import kts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/kts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/kts_front.sv =====
// Front end: accepts input words, classifies the command and holds them in a
// two-entry queue for the back end. Depends on kts_pkg and kts_if.
module kts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  kts_item_if.sink      item_if,
  output kts_pkg::op_t  op_o,
  output logic          op_valid_o,
  input  logic          op_ready_i
);
  import kts_pkg::*;

  op_t        fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  op_t        op_in;
  logic       push, pop;

  // Classify the incoming word
  always_comb begin
    op_in.op      = op_e'(item_if.cmd);
    op_in.now_ms  = item_if.now_ms;
    op_in.entry   = item_if.entry_index;
    op_in.chan    = item_if.channel_index;
    op_in.goal    = item_if.goal_value;
    op_in.dur     = item_if.entry_duration;
    op_in.mask    = item_if.entry_mask;
    op_in.load_ok = (32'(item_if.entry_index) < KEYFRAMES) &&
                    (32'(item_if.channel_index) < CHANNELS);
  end

  assign item_if.ready = (cnt_q != 2'd2);
  assign push          = item_if.valid && item_if.ready;
  assign op_valid_o    = (cnt_q != 2'd0);
  assign pop           = op_valid_o && op_ready_i;
  assign op_o          = fifo_q[rd_ptr_q];

  // Advance queue pointers
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued words
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= op_in;
    end
  end
endmodule

// ===== rtl/kts_back.sv =====
// Back end: executes loads, play, stop and ticks; serial divide, tween weight,
// per-channel update and result emission. Depends on kts_pkg, kts_if, kts_ram.
module kts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kts_pkg::cfg_t cfg_i,
  input  kts_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  kts_res_if.source     res_if
);
  import kts_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_ELAP  = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_SQ    = 9'b000010000,
    S_CUBE  = 9'b000100000,
    S_RD    = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_WR    = 9'b100000000
  } state_e;

  localparam int V = VALUE_BITS;
  localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(CHANNELS - 1);
  localparam logic signed [V+1:0] VMAX = (V+2)'((64'sd1 <<< (V - 1)) - 1);
  localparam logic signed [V+1:0] VMIN = (V+2)'(-(64'sd1 <<< (V - 1)));

  state_e               state_q, state_d;
  logic                 emit_q, emit_d;
  logic                 playing_q, playing_d;
  logic [COUNT_W-1:0]   fi_q, fi_d;
  logic [TIME_W-1:0]    fs_q, fs_d;
  logic [TIME_W-1:0]    now_q, now_d;
  logic                 snap_q, snap_d;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic [DUR_W-1:0]     dur_q, dur_d;
  logic [T_W-1:0]       rem_q, rem_d;
  logic [T_W-1:0]       quo_q, quo_d;
  logic [3:0]           step_q, step_d;
  logic [2*T_W-1:0]     sq_q, sq_d;
  logic [TW_W-1:0]      w_q, w_d;
  logic [CH_BITS-1:0]   ch_q, ch_d;
  logic signed [V-1:0]  goal_q, goal_d;
  logic [V:0]           mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic signed [V-1:0]  cv_q [CHANNELS];
  logic signed [V-1:0]  cv_d [CHANNELS];
  logic [DUR_W-1:0]     dur_tab_q [KEYFRAMES];
  logic [MASK_W-1:0]    mask_tab_q [KEYFRAMES];

  logic                 rv_q, rv_d;
  logic [CH_BITS-1:0]   rch_q, rch_d;
  logic signed [V-1:0]  rval_q, rval_d;
  logic                 rplay_q, rplay_d;
  logic [COUNT_W-1:0]   rframe_q, rframe_d;
  logic                 rlast_q, rlast_d;

  logic                 tab_we;
  logic [GOAL_AW-1:0]   goal_raddr, goal_waddr;
  logic [V-1:0]         goal_rdata;

  // Working values of the datapath
  logic [COUNT_W-1:0]   count;
  logic [TIME_W-1:0]    elapsed;
  logic [T_W:0]         rem2;
  logic                 ge;
  logic [3*T_W-1:0]     cube;
  logic [LUT_BITS-1:0]  lut_idx;
  logic signed [V:0]    diff;
  logic [V:0]           absd;
  logic [V+TW_W:0]      prod;
  logic signed [V+1:0]  nv;
  logic signed [V+1:0]  step_amt;
  logic signed [V-1:0]  sat_v;
  logic                 in_mask;

  assign goal_waddr = {op_i.entry[KF_BITS-1:0], op_i.chan[CH_BITS-1:0]};
  assign goal_raddr = {fi_q[KF_BITS-1:0], ch_q};

  kts_ram #(.WIDTH(V), .DEPTH(GOAL_DEPTH)) u_goal_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(goal_waddr),
    .wdata_i(op_i.goal),
    .raddr_i(goal_raddr),
    .rdata_o(goal_rdata)
  );

  assign op_ready_o      = (state_q == S_IDLE) && !emit_q;
  assign tab_we          = op_valid_i && op_ready_o && (op_i.op == OP_LOAD) && op_i.load_ok;
  assign res_if.valid       = rv_q;
  assign res_if.out_channel = CHAN_W'(rch_q);
  assign res_if.out_value   = rval_q;
  assign res_if.is_playing  = rplay_q;
  assign res_if.frame_now   = rframe_q;
  assign res_if.last        = rlast_q;

  // Datapath terms
  always_comb begin
    count    = (32'(cfg_i.kf_count) > KEYFRAMES) ? COUNT_W'(KEYFRAMES) : cfg_i.kf_count;
    elapsed  = now_q - fs_q;
    rem2     = {rem_q, 1'b0};
    ge       = (rem2 >= {1'b0, dur_q});
    cube     = sq_q * quo_q;
    lut_idx  = quo_q[T_W-1 -: LUT_BITS];
    diff     = {goal_rdata[V-1], goal_rdata} - {cv_q[ch_q][V-1], cv_q[ch_q]};
    absd     = diff[V] ? (V+1)'(-diff) : (V+1)'(diff);
    prod     = absd * w_q;
    step_amt = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    nv       = $signed({{2{cv_q[ch_q][V-1]}}, cv_q[ch_q]}) + step_amt;
    sat_v    = (nv > VMAX) ? VMAX[V-1:0] : (nv < VMIN) ? VMIN[V-1:0] : nv[V-1:0];
    in_mask  = mask_q[ch_q];
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    emit_d    = emit_q;
    playing_d = playing_q;
    fi_d      = fi_q;
    fs_d      = fs_q;
    now_d     = now_q;
    snap_d    = snap_q;
    mask_d    = mask_q;
    dur_d     = dur_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    sq_d      = sq_q;
    w_d       = w_q;
    ch_d      = ch_q;
    goal_d    = goal_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    cv_d      = cv_q;
    rv_d      = res_if.ready ? 1'b0 : rv_q;
    rch_d     = rch_q;
    rval_d    = rval_q;
    rplay_d   = rplay_q;
    rframe_d  = rframe_q;
    rlast_d   = rlast_q;

    // Emit one result per channel after a tick
    if (emit_q && (!rv_q || res_if.ready)) begin
      rv_d     = 1'b1;
      rch_d    = ch_q;
      rval_d   = cv_q[ch_q];
      rplay_d  = playing_q;
      rframe_d = fi_q;
      rlast_d  = (ch_q == CH_LAST);
      ch_d     = ch_q + 1'b1;
      if (ch_q == CH_LAST) begin
        emit_d = 1'b0;
        ch_d   = '0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (op_valid_i && op_ready_o) begin
          case (op_i.op)
            OP_PLAY: begin
              if (!playing_q) begin
                fs_d      = op_i.now_ms;
                fi_d      = '0;
                playing_d = 1'b1;
              end
            end
            OP_STOP: playing_d = 1'b0;
            OP_TICK: begin
              now_d = op_i.now_ms;
              ch_d  = '0;
              if (playing_q) state_d = S_CHECK;
              else           emit_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (fi_q >= count) begin
          if (cfg_i.loop_en && (count != '0)) begin
            fi_d    = '0;
            state_d = S_ELAP;
          end else begin
            playing_d = 1'b0;
            emit_d    = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_ELAP;
        end
      end
      S_ELAP: begin
        dur_d  = dur_tab_q[fi_q[KF_BITS-1:0]];
        mask_d = mask_tab_q[fi_q[KF_BITS-1:0]];
        rem_d  = elapsed[T_W-1:0];
        quo_d  = '0;
        step_d = '0;
        ch_d   = '0;
        if (elapsed >= TIME_W'(dur_tab_q[fi_q[KF_BITS-1:0]])) begin
          snap_d  = 1'b1;
          state_d = S_RD;
        end else begin
          snap_d  = 1'b0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = ge ? T_W'(rem2 - {1'b0, dur_q}) : rem2[T_W-1:0];
        quo_d  = {quo_q[T_W-2:0], ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) state_d = S_SQ;
      end
      S_SQ: begin
        sq_d    = quo_q * quo_q;
        state_d = S_CUBE;
      end
      S_CUBE: begin
        case (tween_e'(cfg_i.tween_mode))
          TW_SQUARE: w_d = TW_W'(sq_q[2*T_W-1:T_W]);
          TW_CUBIC:  w_d = TW_W'(cube[3*T_W-1:2*T_W]);
          TW_SINE:   w_d = SIN_LUT[lut_idx*TW_W +: TW_W];
          TW_COSINE: w_d = COS_LUT[lut_idx*TW_W +: TW_W];
          default:   w_d = TW_W'(quo_q);
        endcase
        ch_d    = '0;
        state_d = S_RD;
      end
      S_RD: state_d = S_MUL;
      S_MUL: begin
        goal_d  = goal_rdata;
        mag_d   = prod[V+T_W:T_W];
        neg_d   = diff[V];
        state_d = S_WR;
      end
      S_WR: begin
        if (in_mask) begin
          cv_d[ch_q] = snap_q ? goal_q : sat_v;
        end
        if (ch_q == CH_LAST) begin
          if (snap_q) begin
            fs_d = now_q;
            fi_d = fi_q + 1'b1;
          end
          ch_d    = '0;
          emit_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      emit_q    <= 1'b0;
      playing_q <= 1'b0;
      fi_q      <= '0;
      fs_q      <= '0;
      ch_q      <= '0;
      rv_q      <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) cv_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      emit_q    <= emit_d;
      playing_q <= playing_d;
      fi_q      <= fi_d;
      fs_q      <= fs_d;
      ch_q      <= ch_d;
      rv_q      <= rv_d;
      cv_q      <= cv_d;
    end
  end

  // Payload registers and keyframe tables
  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    snap_q   <= snap_d;
    mask_q   <= mask_d;
    dur_q    <= dur_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    step_q   <= step_d;
    sq_q     <= sq_d;
    w_q      <= w_d;
    goal_q   <= goal_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    rch_q    <= rch_d;
    rval_q   <= rval_d;
    rplay_q  <= rplay_d;
    rframe_q <= rframe_d;
    rlast_q  <= rlast_d;
    if (tab_we) begin
      dur_tab_q[op_i.entry[KF_BITS-1:0]]  <= op_i.dur;
      mask_tab_q[op_i.entry[KF_BITS-1:0]] <= op_i.mask;
    end
  end
endmodule

// ===== rtl/keyframe_tween_sequencer.sv =====
// Top level of the keyframe tween sequencer: configuration registers, front
// end queue and back end sequencer. Depends on kts_pkg, kts_if, kts_front, kts_back.
//
// Usage: item_if carries commands (tick, load, play, stop) with valid/ready.
// cfg_if writes loop_enable (index 0), tween_mode (1) and keyframe_count (2);
// it is always ready, and it must be written only while the block is idle;
// the block itself does not enforce this. Each tick produces eight words on
// res_if, channel 0 first, last set on the final one; load, play and stop
// produce none. A word passes through the queue to the back end, which
// carries out a load, play or stop from its idle state. A tick while stopped
// is answered from idle, and a tick that ends playback after its check. A
// tick that snaps to the goals runs the check, then the update pass per
// channel (goal RAM read, multiply, add); mid-keyframe, the serial divider and
// the tween weight come before that pass. The 8 output words then follow one
// per cycle while the receiver is ready. The back end handles one command at
// a time; a two-entry queue in front lets the sender continue while a tick is
// worked on. Reset clears playback state, channel values and configuration;
// the keyframe tables hold garbage until loaded. A stalled receiver holds the
// output register and, once the queue is full, the input stalls too.
module keyframe_tween_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  kts_item_if.sink  item_if,
  kts_res_if.source res_if,
  kts_cfg_if.sink   cfg_if
);
  import kts_pkg::*;

  cfg_t cfg_q, cfg_d;
  op_t  op;
  logic op_valid, op_ready;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_LOOP:  cfg_d.loop_en    = cfg_if.data[0];
        REG_MODE:  cfg_d.tween_mode = cfg_if.data[MODE_W-1:0];
        REG_COUNT: cfg_d.kf_count   = cfg_if.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  kts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_if   (item_if),
    .op_o      (op),
    .op_valid_o(op_valid),
    .op_ready_i(op_ready)
  );

  kts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .op_i      (op),
    .op_valid_i(op_valid),
    .op_ready_o(op_ready),
    .res_if    (res_if)
  );
endmodule

// ===== rtl/kts_checker.sv =====
// Port-level checks of the keyframe tween sequencer, bound to the top level.
// Depends on kts_pkg.
module kts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            res_valid_i,
  input logic                            res_ready_i,
  input logic [kts_pkg::CHAN_W-1:0]      out_channel_i,
  input logic [kts_pkg::VALUE_BITS-1:0]  out_value_i,
  input logic [kts_pkg::COUNT_W-1:0]     frame_now_i,
  input logic                            last_i
);
  import kts_pkg::*;

  // A stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(out_channel_i) && $stable(out_value_i))
    else $error("result changed while stalled");

  // The final word of a tick is the top channel
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && last_i |-> 32'(out_channel_i) == CHANNELS - 1)
    else $error("last flag on wrong channel");

  // Only the top channel carries the last flag
  a_notlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_i |-> 32'(out_channel_i) != CHANNELS - 1)
    else $error("top channel without last flag");

  // Frame index never passes the table size
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> 32'(frame_now_i) <= KEYFRAMES)
    else $error("frame index out of range");
endmodule

bind keyframe_tween_sequencer kts_checker u_kts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_if.valid),
  .res_ready_i  (res_if.ready),
  .out_channel_i(res_if.out_channel),
  .out_value_i  (res_if.out_value),
  .frame_now_i  (res_if.frame_now),
  .last_i       (res_if.last)
);

// ===== tb/tb.sv =====
// Self-checking testbench for keyframe_tween_sequencer: random and directed
// command words, a built-in playback predictor and a result scoreboard.
// Depends on kts_pkg, kts_if and keyframe_tween_sequencer from the rtl folder.
`timescale 1ns / 100ps

module tb;
  import kts_pkg::*;

  typedef struct {
    op_e                          op;
    logic [TIME_W-1:0]            now_ms;
    logic [ENTRY_W-1:0]           entry;
    logic [CHAN_W-1:0]            chan;
    logic signed [VALUE_BITS-1:0] goal;
    logic [DUR_W-1:0]             dur;
    logic [MASK_W-1:0]            mask;
  } cmd_word_t;

  typedef struct {
    logic [CHAN_W-1:0]            chan;
    logic signed [VALUE_BITS-1:0] value;
    logic                         playing;
    logic [COUNT_W-1:0]           frame;
    logic                         last;
  } chan_word_t;

  localparam longint ONE_Q30  = 64'sd1 << 30;
  localparam longint QPI_Q30  = 64'sd1686629713;
  localparam int     LIMIT    = 600000;

  logic clk_i;
  logic rst_ni;

  kts_item_if item_if ();
  kts_res_if  res_if ();
  kts_cfg_if  cfg_if ();

  keyframe_tween_sequencer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_if(item_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  cmd_word_t  pending_words[$];
  chan_word_t expected_words[$];
  cmd_word_t  cur_word;
  int         err_count = 0;
  int         send_idle_pct;
  int         rcv_stall_pct;
  logic       rcv_hold = 1'b0;
  int         cycle_count = 0;
  logic [TIME_W-1:0] sim_ms;

  // Sequencer image
  logic signed [VALUE_BITS-1:0] goal_img [GOAL_DEPTH];
  logic [DUR_W-1:0]             dur_img  [KEYFRAMES];
  logic [MASK_W-1:0]            mask_img [KEYFRAMES];
  logic signed [VALUE_BITS-1:0] chan_img [CHANNELS];
  logic [COUNT_W-1:0]           frame_img;
  logic [TIME_W-1:0]            frame_t0;
  logic                         play_img;
  logic                         loop_img;
  logic [MODE_W-1:0]            mode_img;
  logic [COUNT_W-1:0]           count_img;

  task automatic report(input string msg);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Quarter-wave Taylor sum in Q30, sine for odd, else cosine
  function automatic longint quarter_wave(input longint x, input bit odd);
    longint term, sum, n;
    term = odd ? x : ONE_Q30;
    sum  = term;
    n    = odd ? 1 : 0;
    for (int k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / ((n + 1) * (n + 2));
      n += 2;
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    return (sum < 0) ? 0 : sum;
  endfunction

  function automatic longint trig_weight(input longint t, input bit cosine);
    longint idx, q4, quad, u, x, s, c, v, r;
    idx  = (t * SINE_TABLE_DEPTH) >> 16;
    q4   = 4 * idx;
    quad = q4 / SINE_TABLE_DEPTH;
    u    = ((q4 % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
    x    = (u * QPI_Q30) >> 30;
    s    = quarter_wave(x, 1'b1);
    c    = quarter_wave(x, 1'b0);
    if (!cosine) v = (quad == 0) ? s : (quad == 1) ? c : (quad == 2) ? -s : -c;
    else         v = (quad == 0) ? c : (quad == 1) ? -s : (quad == 2) ? -c : s;
    r = ONE_Q30 + v + (64'sd1 << 14);
    if (r < 0) r = 0;
    r = r >> 15;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic longint tween_weight(input longint t);
    case (mode_img)
      TW_SQUARE: return (t * t) >> 16;
      TW_CUBIC:  return (t * t * t) >> 32;
      TW_SINE:   return trig_weight(t, 1'b0);
      TW_COSINE: return trig_weight(t, 1'b1);
      default:   return t;
    endcase
  endfunction

  // Move the playback image one tick forward
  task automatic advance_playback(input logic [TIME_W-1:0] now);
    int unsigned cnt;
    logic [TIME_W-1:0] elapsed;
    longint t, w, diff, mag, nv;
    logic [KF_BITS-1:0] fk;
    cnt = (count_img > KEYFRAMES) ? KEYFRAMES : count_img;
    if (!play_img) return;
    if (frame_img >= cnt) begin
      if (loop_img && cnt > 0) frame_img = '0;
      else begin
        play_img = 1'b0;
        return;
      end
    end
    fk      = frame_img[KF_BITS-1:0];
    elapsed = now - frame_t0;
    if (elapsed >= dur_img[fk]) begin
      for (int c = 0; c < CHANNELS; c++)
        if (mask_img[fk][c]) chan_img[c] = goal_img[{fk, CH_BITS'(c)}];
      frame_t0  = now;
      frame_img = frame_img + 1'b1;
    end else begin
      t = (longint'(elapsed) << 16) / longint'(dur_img[fk]);
      w = tween_weight(t);
      for (int c = 0; c < CHANNELS; c++) begin
        if (!mask_img[fk][c]) continue;
        diff = longint'(goal_img[{fk, CH_BITS'(c)}]) - longint'(chan_img[c]);
        mag  = ((diff < 0 ? -diff : diff) * w) >> 16;
        nv   = longint'(chan_img[c]) + (diff < 0 ? -mag : mag);
        if (nv < -32768) nv = -32768;
        if (nv > 32767) nv = 32767;
        chan_img[c] = nv[VALUE_BITS-1:0];
      end
    end
  endtask

  // Apply one accepted word and queue the channel words it causes
  task automatic predict_word(input cmd_word_t w);
    chan_word_t r;
    case (w.op)
      OP_LOAD: begin
        goal_img[{w.entry, w.chan}] = w.goal;
        dur_img[w.entry]  = w.dur;
        mask_img[w.entry] = w.mask;
      end
      OP_PLAY: begin
        if (!play_img) begin
          frame_t0  = w.now_ms;
          frame_img = '0;
          play_img  = 1'b1;
        end
      end
      OP_STOP: play_img = 1'b0;
      default: begin
        advance_playback(w.now_ms);
        for (int c = 0; c < CHANNELS; c++) begin
          r.chan    = c[CHAN_W-1:0];
          r.value   = chan_img[c];
          r.playing = play_img;
          r.frame   = frame_img;
          r.last    = (c == CHANNELS - 1);
          expected_words.insert(expected_words.size(), r);
        end
      end
    endcase
  endtask

  function automatic cmd_word_t noise_word(input op_e op, input logic [TIME_W-1:0] now);
    cmd_word_t w;
    w.op     = op;
    w.now_ms = now;
    w.entry  = ENTRY_W'($urandom);
    w.chan   = CHAN_W'($urandom);
    w.goal   = VALUE_BITS'($urandom);
    w.dur    = DUR_W'($urandom);
    w.mask   = MASK_W'($urandom);
    return w;
  endfunction

  task automatic push_load(input int e, input int c, input int g, input int d, input int m);
    cmd_word_t w;
    w       = noise_word(OP_LOAD, $urandom);
    w.entry = ENTRY_W'(e);
    w.chan  = CHAN_W'(c);
    w.goal  = VALUE_BITS'(g);
    w.dur   = DUR_W'(d);
    w.mask  = MASK_W'(m);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic push_op(input op_e op, input logic [TIME_W-1:0] now);
    pending_words.insert(pending_words.size(), noise_word(op, now));
  endtask

  function automatic int rand_dur();
    case ($urandom_range(15))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(65535);
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  function automatic int rand_goal();
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // Write one register and mirror it in the image
  task automatic cfg_write(input cfg_reg_e idx, input int data);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(data);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_LOOP:  loop_img  = data[0];
      REG_MODE:  mode_img  = data[MODE_W-1:0];
      REG_COUNT: count_img = data[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || item_if.valid || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; rcv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rcv_stall_pct = 48; end
      default: begin send_idle_pct = 21; rcv_stall_pct = 21; end
    endcase
  endtask

  // One burst of playback: a play, then mostly ticks with some loads, stops and plays
  task automatic random_burst(input int n);
    int pick;
    push_op(OP_PLAY, sim_ms);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_load($urandom_range(15), $urandom_range(7), rand_goal(), rand_dur(),
                  $urandom_range(255));
      end else if (pick < 13) begin
        push_op(OP_STOP, $urandom);
      end else if (pick < 17) begin
        push_op(OP_PLAY, sim_ms);
      end else if (pick < 19) begin
        push_op(OP_TICK, $urandom);
      end else begin
        sim_ms = sim_ms + $urandom_range(30);
        push_op(OP_TICK, sim_ms);
      end
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Word driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid          <= 1'b0;
      item_if.cmd            <= OP_TICK;
      item_if.now_ms         <= '0;
      item_if.entry_index    <= '0;
      item_if.channel_index  <= '0;
      item_if.goal_value     <= '0;
      item_if.entry_duration <= '0;
      item_if.entry_mask     <= '0;
    end else begin
      if (item_if.valid && item_if.ready) predict_word(cur_word);
      if (!item_if.valid || item_if.ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = pending_words.pop_front();
          item_if.valid          <= 1'b1;
          item_if.cmd            <= cur_word.op;
          item_if.now_ms         <= cur_word.now_ms;
          item_if.entry_index    <= cur_word.entry;
          item_if.channel_index  <= cur_word.chan;
          item_if.goal_value     <= cur_word.goal;
          item_if.entry_duration <= cur_word.dur;
          item_if.entry_mask     <= cur_word.mask;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    chan_word_t e;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word ch %0d", res_if.out_channel));
        end else begin
          e = expected_words.pop_front();
          if (res_if.out_channel !== e.chan)
            report($sformatf("channel %0d, want %0d", res_if.out_channel, e.chan));
          if (res_if.out_value !== e.value)
            report($sformatf("ch %0d value %0d, want %0d", e.chan, res_if.out_value,
                             e.value));
          if (res_if.is_playing !== e.playing)
            report($sformatf("ch %0d playing %b, want %b", e.chan, res_if.is_playing,
                             e.playing));
          if (res_if.frame_now !== e.frame)
            report($sformatf("ch %0d frame %0d, want %0d", e.chan, res_if.frame_now,
                             e.frame));
          if (res_if.last !== e.last)
            report($sformatf("ch %0d last %b, want %b", e.chan, res_if.last, e.last));
        end
      end
      res_if.ready <= !rcv_hold && ($urandom_range(99) >= rcv_stall_pct);
    end else begin
      res_if.ready <= 1'b0;
    end
  end

  // Timeout watch
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = REG_LOOP;
    cfg_if.data   = '0;
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    sim_ms        = 32'd5000;
    for (int c = 0; c < CHANNELS; c++) chan_img[c] = '0;
    frame_img = '0;
    frame_t0  = '0;
    play_img  = 1'b0;
    loop_img  = 1'b0;
    mode_img  = TW_LINEAR;
    count_img = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Fill every slot so playback never reads an unwritten entry
    cfg_write(REG_LOOP, 0);
    cfg_write(REG_MODE, TW_LINEAR);
    cfg_write(REG_COUNT, 0);
    for (int e = 0; e < KEYFRAMES; e++)
      for (int c = 0; c < CHANNELS; c++)
        push_load(e, c, rand_goal(), rand_dur(), $urandom_range(255));
    // Count zero: tick while stopped, then a play that the tick stops
    push_op(OP_TICK, 32'd0);
    push_op(OP_STOP, 32'd0);
    push_op(OP_PLAY, 32'd100);
    push_op(OP_TICK, 32'd150);
    push_op(OP_TICK, 32'hFFFF_FFFF);
    drain();

    // Extremes of goal and duration, zero duration, play while playing, looping
    cfg_write(REG_LOOP, 1);
    cfg_write(REG_COUNT, 2);
    push_load(0, 0, 32767, 65535, 8'hFF);
    push_load(0, 1, -32768, 65535, 8'hFF);
    push_load(1, 0, -32768, 0, 8'h01);
    push_op(OP_PLAY, 32'd1000);
    push_op(OP_PLAY, 32'd2000);
    push_op(OP_TICK, 32'd1000);
    push_op(OP_TICK, 32'd1000 + 32767);
    push_op(OP_TICK, 32'd1000 + 65534);
    push_op(OP_TICK, 32'd1000 + 65535);
    push_op(OP_TICK, 32'd1000 + 65535);
    push_op(OP_TICK, 32'd1000 + 65536);
    push_op(OP_STOP, 32'd0);
    push_op(OP_TICK, 32'd0);
    drain();

    // Random phases over every mode, both loop settings and several counts, some past the table size
    for (int p = 0; p < 9; p++) begin
      set_idling(p);
      cfg_write(REG_LOOP, p % 2);
      cfg_write(REG_MODE, p % 8);
      case (p)
        0:       cfg_write(REG_COUNT, 16);
        1:       cfg_write(REG_COUNT, 1);
        2:       cfg_write(REG_COUNT, 20);
        3:       cfg_write(REG_COUNT, 31);
        default: cfg_write(REG_COUNT, $urandom_range(16));
      endcase
      if (p == 5) sim_ms = 32'hFFFF_FFE0;
      push_op(OP_STOP, 32'd0);
      random_burst(16);
      if (p == 2) begin
        fork
          begin
            rcv_hold <= 1'b1;
            repeat (700) @(posedge clk_i);
            rcv_hold <= 1'b0;
          end
        join_none
      end
      drain();
    end

    if (err_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kts_pkg.sv
rtl/kts_if.sv
rtl/kts_ram.sv
rtl/kts_front.sv
rtl/kts_back.sv
rtl/keyframe_tween_sequencer.sv
rtl/kts_checker.sv
tb/tb.sv
